// File: design/first_fit_heap_allocator_assert.svh
// Assertion macros for the first-fit heap allocator.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked at every clock edge out of reset
`define FFHA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ffha assertion failed");

// Next-cycle implication
`define FFHA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ffha assertion failed");

`endif

// File: design/ffha_pkg.sv
// Shared types, codes and constants of the first-fit heap allocator.
`timescale 1ns / 1ps
package ffha_pkg;

  localparam int MAX_BLOCKS_DEF = 64;
  localparam int HEADER_BYTES   = 16;
  // Page size must be a power of two
  localparam int PAGE_BYTES     = 4096;

  localparam logic [31:0] HDR32       = 32'(HEADER_BYTES);
  localparam logic [33:0] PAGE_MASK34 = ~34'(PAGE_BYTES - 1);
  localparam logic [32:0] PAGE_MASK33 = ~33'(PAGE_BYTES - 1);

  // Command codes
  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_FREE    = 2'd1;
  localparam logic [1:0] CMD_REALLOC = 2'd2;
  localparam logic [1:0] CMD_INIT    = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_INIT  = 3'd1;
  localparam logic [2:0] ST_ZERO      = 3'd2;
  localparam logic [2:0] ST_EXHAUSTED = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_DOUBLE    = 3'd5;
  localparam logic [2:0] ST_UNKNOWN   = 3'd6;
  localparam logic [2:0] ST_NULL      = 3'd7;

  // Operation broadcast to every cell of the row
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INIT,
    OP_SPLIT,
    OP_TAKE,
    OP_FREE,
    OP_APPEND,
    OP_MERGE
  } cell_op_t;

  typedef struct packed {
    logic [31:0] off;
    logic [31:0] size;
    logic        free;
  } entry_t;

  typedef struct packed {
    cell_op_t    op;
    logic [31:0] req;
    logic [31:0] addr;
    logic [31:0] init_size;
  } ctrl_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] req_size;
    logic [31:0] address;
  } ffha_req_t;

  typedef struct packed {
    logic [31:0] result_address;
    logic [2:0]  status;
    logic [31:0] heap_bytes;
  } ffha_rsp_t;

endpackage

// File: design/ffha_cell.sv
// One table entry of the block row: holds a block and shifts with its neighbors.
`timescale 1ns / 1ps
module ffha_cell import ffha_pkg::*; #(
  parameter int IDX_W    = 6,
  parameter int CELL_IDX = 0
) (
  input  logic             clk,
  input  ctrl_t            ctrl,
  input  logic [IDX_W-1:0] idx,
  input  entry_t           left,
  input  entry_t           right,
  output entry_t           ent
);

  localparam int OW = IDX_W + 1;
  localparam logic [IDX_W:0] OWN = OW'(CELL_IDX);

  entry_t      ent_r;
  entry_t      ent_nxt;
  logic        at_idx;
  logic        at_next;
  logic        past_idx;
  logic [31:0] base;

  // Position of this cell relative to the addressed entry
  assign at_idx   = ({1'b0, idx} == OWN);
  assign at_next  = (({1'b0, idx} + 1'b1) == OWN);
  assign past_idx = (OWN > {1'b0, idx});

  // End of the left neighbor, where an appended block starts
  assign base = (CELL_IDX == 0) ? 32'd0 : (left.off + left.size + HDR32);

  // Apply the broadcast operation
  always_comb begin
    ent_nxt = ent_r;
    unique case (ctrl.op)
      OP_HOLD: begin
      end
      OP_INIT: begin
        if (at_idx) begin
          ent_nxt.off  = 32'd0;
          ent_nxt.size = ctrl.init_size;
          ent_nxt.free = 1'b1;
        end
      end
      OP_SPLIT: begin
        if (at_idx) begin
          ent_nxt.size = ctrl.req;
          ent_nxt.free = 1'b0;
        end else if (at_next) begin
          ent_nxt.off  = left.off + HDR32 + ctrl.req;
          ent_nxt.size = left.size - ctrl.req - HDR32;
          ent_nxt.free = 1'b1;
        end else if (past_idx) begin
          ent_nxt = left;
        end
      end
      OP_TAKE: begin
        if (at_idx) ent_nxt.free = 1'b0;
      end
      OP_FREE: begin
        if (at_idx) ent_nxt.free = 1'b1;
      end
      OP_APPEND: begin
        if (at_idx) begin
          ent_nxt.off  = base;
          ent_nxt.size = ctrl.req;
          ent_nxt.free = 1'b0;
        end
      end
      OP_MERGE: begin
        if (at_idx) begin
          ent_nxt.size = ent_r.size + HDR32 + right.size;
        end else if (past_idx) begin
          ent_nxt = right;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;

endmodule

// File: design/ffha_row.sv
// Row of block cells with per-cell match flags and a selected-offset read.
`timescale 1ns / 1ps
module ffha_row import ffha_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic                                clk,
  input  ctrl_t                               ctrl,
  input  logic [$clog2(MAX_BLOCKS)-1:0]       idx,
  input  logic [$clog2(MAX_BLOCKS+1)-1:0]     count,
  input  logic [MAX_BLOCKS-1:0]               rd_sel,
  output logic [MAX_BLOCKS-1:0]               fit,
  output logic [MAX_BLOCKS-1:0]               spl,
  output logic [MAX_BLOCKS-1:0]               hit,
  output logic [MAX_BLOCKS-1:0]               fre,
  output logic [MAX_BLOCKS-1:0]               pair,
  output logic [31:0]                         rd_off
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  entry_t               ent [MAX_BLOCKS];
  entry_t               lft [MAX_BLOCKS];
  entry_t               rgt [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] vld;

  for (genvar j = 0; j < MAX_BLOCKS; j++) begin : g_cell
    // Wire neighbors; the row ends see an empty entry
    if (j == 0) begin : g_first
      assign lft[j] = '0;
    end else begin : g_mid_l
      assign lft[j] = ent[j-1];
    end
    if (j == MAX_BLOCKS - 1) begin : g_last
      assign rgt[j]  = '0;
      assign pair[j] = 1'b0;
    end else begin : g_mid_r
      assign rgt[j]  = ent[j+1];
      assign pair[j] = vld[j+1] & ent[j].free & ent[j+1].free;
    end

    ffha_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (j)
    ) u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .idx   (idx),
      .left  (lft[j]),
      .right (rgt[j]),
      .ent   (ent[j])
    );

    // Local compares of each cell against the request
    assign vld[j] = (CNT_W'(j) < count);
    assign fit[j] = vld[j] & ent[j].free & (ent[j].size >= ctrl.req);
    assign spl[j] = ({1'b0, ent[j].size} > ({1'b0, ctrl.req} + 33'(HEADER_BYTES)));
    assign hit[j] = vld[j] & (({1'b0, ent[j].off} + 33'(HEADER_BYTES)) == {1'b0, ctrl.addr});
    assign fre[j] = ent[j].free;
  end

  // Read the offset of the one-hot selected cell
  always_comb begin
    rd_off = '0;
    for (int j = 0; j < MAX_BLOCKS; j++) begin
      rd_off = rd_off | (ent[j].off & {32{rd_sel[j]}});
    end
  end

endmodule

// File: design/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator: command sequencer and config port.
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+-----------------------------------
//  request  | start, busy, in_data           | taken when start && !busy
//  result   | out_valid, out_data            | one-cycle strobe, cannot stall
//  config   | psel penable pwrite paddr ...  | APB write in access phase
//
// One request at a time. Alloc: scan, select, decide, apply, read, result.
// Free: scan, select, decide, apply, one merge-loop round over the cell row
// per merged neighbor, result. Realloc: alloc and free back to back. Init:
// scan, select, decide, apply, result. A failed check ends the request after decide.
// Reset clears block count, mapped size and ready mark; no clearing pass.
// busy stays high through the result strobe; the receiver has no stall.
`timescale 1ns / 1ps
`include "first_fit_heap_allocator_assert.svh"
module first_fit_heap_allocator import ffha_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  ffha_req_t   in_data,
  output logic        out_valid,
  output ffha_rsp_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int N     = MAX_BLOCKS;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_FIND   = 8'b0000_0010,
    S_SEL    = 8'b0000_0100,
    S_DEC    = 8'b0000_1000,
    S_APPLY  = 8'b0001_0000,
    S_READ   = 8'b0010_0000,
    S_MSCAN  = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  // Merge-apply runs in S_MSCAN's partner phase, tracked by a flag
  state_t             state_r, state_nxt;
  logic               mphase_r, mphase_nxt;
  logic               refree_r, refree_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [31:0]        mapped_r, mapped_nxt;
  logic               ready_r, ready_nxt;
  logic [31:0]        init_r;
  logic [31:0]        limit_r;

  logic [1:0]         cmd_r;
  logic [31:0]        req_r;
  logic [31:0]        addr_r;
  logic [2:0]         status_r, status_nxt;
  logic [31:0]        res_addr_r, res_addr_nxt;
  cell_op_t           op_r, op_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [N-1:0]       res_oh_r, res_oh_nxt;

  logic [N-1:0]       fit_r, spl_r, hit_r, fre_r;
  logic [N-1:0]       fit_oh_r;
  logic [IDX_W-1:0]   fit_idx_r, hit_idx_r, pair_idx_r;
  logic               fit_any_r, fit_spl_r, hit_any_r, hit_free_r, pair_any_r;
  logic [33:0]        grown_r;
  logic [31:0]        init_bytes_r;

  logic [N-1:0]       fit, spl, hit, fre, pair;
  logic [31:0]        rd_off;
  ctrl_t              row_ctrl;
  logic [IDX_W-1:0]   row_idx;

  logic [33:0]        need34;
  logic [32:0]        ini33;
  logic [N-1:0]       cnt_oh;
  logic [N-1:0]       pair_oh;

  function automatic logic [N-1:0] first_one(input logic [N-1:0] v);
    return v & (~v + 1'b1);
  endfunction

  function automatic logic [IDX_W-1:0] encode(input logic [N-1:0] oh);
    logic [IDX_W-1:0] e;
    e = '0;
    for (int j = 0; j < N; j++) begin
      if (oh[j]) e = e | IDX_W'(j);
    end
    return e;
  endfunction

  // Configuration port
  assign pready = 1'b1;
  assign prdata = paddr[2] ? limit_r : init_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r  <= 32'd65536;
      limit_r <= 32'd16777216;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) limit_r <= pwdata;
      else          init_r  <= pwdata;
    end
  end

  // Cell row
  ffha_row #(.MAX_BLOCKS(MAX_BLOCKS)) u_row (
    .clk    (clk),
    .ctrl   (row_ctrl),
    .idx    (row_idx),
    .count  (count_r),
    .rd_sel (res_oh_r),
    .fit    (fit),
    .spl    (spl),
    .hit    (hit),
    .fre    (fre),
    .pair   (pair),
    .rd_off (rd_off)
  );

  // Drive the row: one operation per apply cycle or merge phase, hold otherwise
  always_comb begin
    row_ctrl.req       = req_r;
    row_ctrl.addr      = addr_r;
    row_ctrl.init_size = init_bytes_r - HDR32;
    row_ctrl.op        = OP_HOLD;
    row_idx            = idx_r;
    if (state_r == S_APPLY) begin
      row_ctrl.op = op_r;
    end else if (state_r == S_MSCAN && mphase_r && pair_any_r) begin
      row_ctrl.op = OP_MERGE;
      row_idx     = pair_idx_r;
    end
  end

  // Page rounding for growth and init
  always_comb begin
    need34 = ({2'b0, req_r} + 34'(HEADER_BYTES) + 34'(PAGE_BYTES - 1)) & PAGE_MASK34;
    ini33  = ({1'b0, init_r} + 33'(PAGE_BYTES - 1)) & PAGE_MASK33;
    if (ini33[32]) ini33 = ini33 - 33'(PAGE_BYTES);
    if (ini33 == '0) ini33 = 33'(PAGE_BYTES);
  end

  always_comb begin
    for (int j = 0; j < N; j++) cnt_oh[j] = (CNT_W'(j) == count_r);
  end

  assign pair_oh = first_one(pair);

  // Sequencer
  always_comb begin
    logic alloc_kind, free_kind, both_kind;
    logic [2:0] fst, ast;
    cell_op_t aop;
    logic [IDX_W-1:0] aidx;
    logic [N-1:0] aoh;

    state_nxt    = state_r;
    mphase_nxt   = mphase_r;
    refree_nxt   = refree_r;
    count_nxt    = count_r;
    mapped_nxt   = mapped_r;
    ready_nxt    = ready_r;
    status_nxt   = status_r;
    res_addr_nxt = res_addr_r;
    op_nxt       = op_r;
    idx_nxt      = idx_r;
    res_oh_nxt   = res_oh_r;

    alloc_kind = (cmd_r == CMD_ALLOC) || (cmd_r == CMD_REALLOC && addr_r == '0);
    free_kind  = (cmd_r == CMD_FREE) ||
                 (cmd_r == CMD_REALLOC && addr_r != '0 && req_r == '0);
    both_kind  = (cmd_r == CMD_REALLOC) && addr_r != '0 && req_r != '0;

    // Free-side checks in priority order
    priority if (!ready_r)        fst = ST_NOT_INIT;
    else if (addr_r == '0)        fst = ST_NULL;
    else if (!hit_any_r)          fst = ST_UNKNOWN;
    else if (hit_free_r)          fst = ST_DOUBLE;
    else                          fst = ST_OK;

    // Alloc-side decision in priority order
    aop  = OP_HOLD;
    aidx = fit_idx_r;
    aoh  = fit_oh_r;
    priority if (req_r == '0) begin
      ast = ST_ZERO;
    end else if (!ready_r) begin
      ast = ST_NOT_INIT;
    end else if (fit_any_r) begin
      ast = ST_OK;
      aop = (fit_spl_r && count_r < CNT_W'(MAX_BLOCKS)) ? OP_SPLIT : OP_TAKE;
    end else if (count_r >= CNT_W'(MAX_BLOCKS)) begin
      ast = ST_FULL;
    end else if (grown_r > {2'b0, limit_r}) begin
      ast = ST_EXHAUSTED;
    end else begin
      ast  = ST_OK;
      aop  = OP_APPEND;
      aidx = count_r[IDX_W-1:0];
      aoh  = cnt_oh;
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_FIND;
      end
      S_FIND: state_nxt = S_SEL;
      S_SEL:  state_nxt = S_DEC;
      S_DEC: begin
        state_nxt = S_DONE;
        if (refree_r) begin
          if (hit_any_r) begin
            op_nxt    = OP_FREE;
            idx_nxt   = hit_idx_r;
            state_nxt = S_APPLY;
          end
        end else if (cmd_r == CMD_INIT) begin
          op_nxt     = OP_INIT;
          idx_nxt    = '0;
          mapped_nxt = init_bytes_r;
          ready_nxt  = 1'b1;
          status_nxt = ST_OK;
          state_nxt  = S_APPLY;
        end else if (free_kind) begin
          status_nxt = fst;
          if (fst == ST_OK) begin
            op_nxt    = OP_FREE;
            idx_nxt   = hit_idx_r;
            state_nxt = S_APPLY;
          end
        end else if (alloc_kind || (both_kind && fst == ST_OK)) begin
          status_nxt = ast;
          if (ast == ST_OK) begin
            op_nxt     = aop;
            idx_nxt    = aidx;
            res_oh_nxt = aoh;
            if (aop == OP_APPEND) mapped_nxt = grown_r[31:0];
            state_nxt  = S_APPLY;
          end
        end else begin
          status_nxt = fst;
        end
      end
      S_APPLY: begin
        unique case (op_r)
          OP_INIT: begin
            count_nxt = CNT_W'(1);
            state_nxt = S_DONE;
          end
          OP_FREE: begin
            mphase_nxt = 1'b0;
            state_nxt  = S_MSCAN;
          end
          OP_SPLIT, OP_APPEND: begin
            count_nxt = count_r + 1'b1;
            state_nxt = S_READ;
          end
          OP_TAKE: state_nxt = S_READ;
          default: state_nxt = S_DONE;
        endcase
      end
      S_READ: begin
        res_addr_nxt = rd_off + HDR32;
        if (both_kind && !refree_r) begin
          refree_nxt = 1'b1;
          state_nxt  = S_FIND;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MSCAN: begin
        // Alternate: latch leftmost free pair, then merge it
        if (!mphase_r) begin
          mphase_nxt = 1'b1;
        end else if (pair_any_r) begin
          count_nxt  = count_r - 1'b1;
          mphase_nxt = 1'b0;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        refree_nxt = 1'b0;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      mphase_r <= 1'b0;
      refree_r <= 1'b0;
      count_r  <= '0;
      mapped_r <= '0;
      ready_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      mphase_r <= mphase_nxt;
      refree_r <= refree_nxt;
      count_r  <= count_nxt;
      mapped_r <= mapped_nxt;
      ready_r  <= ready_nxt;
    end
  end

  // Request payload and per-step results
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    op_r     <= op_nxt;
    idx_r    <= idx_nxt;
    res_oh_r <= res_oh_nxt;
    if (state_r == S_IDLE && start) begin
      cmd_r      <= in_data.cmd;
      req_r      <= in_data.req_size;
      addr_r     <= in_data.address;
      res_addr_r <= '0;
    end else begin
      res_addr_r <= res_addr_nxt;
    end
    if (state_r == S_FIND) begin
      fit_r <= fit;
      spl_r <= spl;
      hit_r <= hit;
      fre_r <= fre;
    end
    if (state_r == S_SEL) begin
      fit_oh_r     <= first_one(fit_r);
      fit_idx_r    <= encode(first_one(fit_r));
      hit_idx_r    <= encode(first_one(hit_r));
      fit_any_r    <= |fit_r;
      hit_any_r    <= |hit_r;
      fit_spl_r    <= |(first_one(fit_r) & spl_r);
      hit_free_r   <= |(first_one(hit_r) & fre_r);
      grown_r      <= {2'b0, mapped_r} + need34;
      init_bytes_r <= ini33[31:0];
    end
    if (state_r == S_MSCAN && !mphase_r) begin
      pair_idx_r <= encode(pair_oh);
      pair_any_r <= |pair;
    end
  end

  // Result
  assign busy                    = (state_r != S_IDLE);
  assign out_valid               = (state_r == S_DONE);
  assign out_data.result_address = res_addr_r;
  assign out_data.status         = status_r;
  assign out_data.heap_bytes     = mapped_r;

  `FFHA_ASSERT_IMP(a_count_max, 1'b1, count_r <= CNT_W'(MAX_BLOCKS))
  `FFHA_ASSERT_IMP(a_empty_until_init, !ready_r, count_r == '0)
  `FFHA_ASSERT_NXT(a_strobe_single, out_valid, !out_valid)
  `FFHA_ASSERT_NXT(a_accept_busy, start && !busy, busy && !out_valid)

endmodule

// File: bench/ffha_checker.sv
// Checker for the first-fit heap allocator: predicts each result and compares it.
`timescale 1ns / 1ps
module ffha_checker import ffha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  ffha_req_t   in_data,
  input  logic        out_valid,
  input  ffha_rsp_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);

  localparam int NBLK = MAX_BLOCKS_DEF;
  localparam logic [63:0] HDR = 64'(HEADER_BYTES);
  localparam logic [63:0] PAGE = 64'(PAGE_BYTES);
  localparam logic [63:0] MASK = 64'hFFFF_FFFF;

  logic [31:0] blk_off [NBLK];
  logic [31:0] blk_size [NBLK];
  bit          blk_free [NBLK];
  int unsigned blk_cnt;
  logic [31:0] mapped;
  bit          ready;
  logic [31:0] init_cfg;
  logic [31:0] limit_cfg;
  ffha_rsp_t   expected_q[$];

  // Insert a block at idx, shifting the tail up
  function automatic void insert_block(int unsigned idx, logic [63:0] off, logic [63:0] sz,
                                       bit fr);
    for (int unsigned i = blk_cnt; i > idx; i--) begin
      blk_off[i] = blk_off[i-1];
      blk_size[i] = blk_size[i-1];
      blk_free[i] = blk_free[i-1];
    end
    blk_off[idx] = off[31:0];
    blk_size[idx] = sz[31:0];
    blk_free[idx] = fr;
    blk_cnt++;
  endfunction

  function automatic void remove_block(int unsigned idx);
    for (int unsigned i = idx; i + 1 < blk_cnt; i++) begin
      blk_off[i] = blk_off[i+1];
      blk_size[i] = blk_size[i+1];
      blk_free[i] = blk_free[i+1];
    end
    blk_cnt--;
  endfunction

  function automatic int find_block(logic [63:0] a);
    for (int unsigned i = 0; i < blk_cnt; i++)
      if (64'(blk_off[i]) + HDR == a) return int'(i);
    return -1;
  endfunction

  // First fit, split, else grow and append
  function automatic logic [2:0] alloc_block(logic [31:0] req, output logic [31:0] addr);
    logic [63:0] pages;
    logic [63:0] grown;
    logic [63:0] base;
    addr = '0;
    if (req == 0) return ST_ZERO;
    if (!ready) return ST_NOT_INIT;
    for (int unsigned i = 0; i < blk_cnt; i++) begin
      if (blk_free[i] && blk_size[i] >= req) begin
        if (64'(blk_size[i]) > 64'(req) + HDR && blk_cnt < NBLK) begin
          insert_block(i + 1, 64'(blk_off[i]) + HDR + 64'(req),
                       64'(blk_size[i]) - 64'(req) - HDR, 1'b1);
          blk_size[i] = req;
        end
        blk_free[i] = 1'b0;
        addr = 32'((64'(blk_off[i]) + HDR) & MASK);
        return ST_OK;
      end
    end
    pages = (64'(req) + HDR + PAGE - 1) / PAGE;
    grown = 64'(mapped) + pages * PAGE;
    base = '0;
    if (blk_cnt >= NBLK) return ST_FULL;
    if (grown > 64'(limit_cfg)) return ST_EXHAUSTED;
    mapped = grown[31:0];
    if (blk_cnt > 0)
      base = 64'(blk_off[blk_cnt-1]) + HDR + 64'(blk_size[blk_cnt-1]);
    insert_block(blk_cnt, base, 64'(req), 1'b0);
    addr = 32'((base + HDR) & MASK);
    return ST_OK;
  endfunction

  function automatic logic [2:0] check_release(logic [31:0] a, output int idx);
    idx = -1;
    if (!ready) return ST_NOT_INIT;
    if (a == 0) return ST_NULL;
    idx = find_block(64'(a));
    if (idx < 0) return ST_UNKNOWN;
    if (blk_free[idx]) return ST_DOUBLE;
    return ST_OK;
  endfunction

  // Mark free, then fold every run of free entries into its first entry
  function automatic void release_block(int idx);
    int unsigned i;
    blk_free[idx] = 1'b1;
    i = 0;
    while (i < blk_cnt) begin
      if (blk_free[i]) begin
        while (i + 1 < blk_cnt && blk_free[i+1]) begin
          blk_size[i] = 32'((64'(blk_size[i]) + HDR + 64'(blk_size[i+1])) & MASK);
          remove_block(i + 1);
        end
      end
      i++;
    end
  endfunction

  function automatic logic [2:0] free_block(logic [31:0] a);
    int idx;
    logic [2:0] st;
    st = check_release(a, idx);
    if (st == ST_OK) release_block(idx);
    return st;
  endfunction

  function automatic void init_heap();
    logic [63:0] bytes;
    bytes = ((64'(init_cfg) + PAGE - 1) / PAGE) * PAGE;
    if (bytes > MASK) bytes = bytes - PAGE;
    if (bytes < PAGE) bytes = PAGE;
    mapped = bytes[31:0];
    ready = 1'b1;
    blk_cnt = 0;
    insert_block(0, 64'd0, bytes - HDR, 1'b1);
  endfunction

  function automatic ffha_rsp_t predict_rsp(ffha_req_t r);
    ffha_rsp_t rsp;
    logic [31:0] a;
    logic [2:0] st;
    int idx;
    a = '0;
    st = ST_OK;
    case (r.cmd)
      CMD_ALLOC: st = alloc_block(r.req_size, a);
      CMD_FREE: st = free_block(r.address);
      CMD_REALLOC: begin
        if (r.address == 0) st = alloc_block(r.req_size, a);
        else if (r.req_size == 0) st = free_block(r.address);
        else begin
          st = check_release(r.address, idx);
          if (st == ST_OK) begin
            st = alloc_block(r.req_size, a);
            if (st == ST_OK) begin
              idx = find_block(64'(r.address));
              if (idx >= 0) release_block(idx);
            end
          end
        end
      end
      default: init_heap();
    endcase
    rsp.result_address = a;
    rsp.status = st;
    rsp.heap_bytes = mapped;
    return rsp;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s mismatch: got 0x%08h, expected 0x%08h", $time, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;

  // Track config writes, predict on each request, compare each result
  always @(posedge clk) begin
    ffha_rsp_t want;
    if (!rst_n) begin
      init_cfg <= 32'd65536;
      limit_cfg <= 32'd16777216;
      blk_cnt = 0;
      mapped = '0;
      ready = 1'b0;
      expected_q.delete();
      pending <= 0;
    end else begin
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          report_mismatch("outstanding requests", 32'd1, 32'd0);
        end else begin
          want = expected_q.pop_front();
          if (out_data.result_address !== want.result_address)
            report_mismatch("result_address", out_data.result_address, want.result_address);
          if (out_data.status !== want.status)
            report_mismatch("status", 32'(out_data.status), 32'(want.status));
          if (out_data.heap_bytes !== want.heap_bytes)
            report_mismatch("heap_bytes", out_data.heap_bytes, want.heap_bytes);
        end
      end
      if (start && !busy) expected_q.push_back(predict_rsp(in_data));
      if (psel && penable && pwrite && pready) begin
        if (paddr == 3'd0) init_cfg <= pwdata;
        else if (paddr == 3'd4) limit_cfg <= pwdata;
      end
      pending <= expected_q.size();
    end
  end

endmodule

// File: bench/tb_first_fit_heap_allocator.sv
// Testbench top for the first-fit heap allocator: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module tb_first_fit_heap_allocator;
  import ffha_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam logic [2:0] REG_INIT_SIZE = 3'd0;
  localparam logic [2:0] REG_LIMIT = 3'd4;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  ffha_req_t   in_data;
  logic        out_valid;
  ffha_rsp_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  int          stall_cycles;
  bit          calm;
  logic [31:0] live_q[$];

  first_fit_heap_allocator u_dut (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  ffha_checker u_checker (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .fail_count, .pending
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Harvest live payload offsets for well-formed frees
  always @(posedge clk) begin
    if (rst_n && out_valid && out_data.status == ST_OK && out_data.result_address != 0)
      live_q.push_back(out_data.result_address);
  end

  // Abort if nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("first_fit_heap_allocator test failed");
      $finish;
    end
  end

  // Issue one request, with an occasional random gap ahead of it
  task automatic send(input logic [1:0] cmd, input logic [31:0] sz, input logic [31:0] a);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(99) < 15) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= '{cmd: cmd, req_size: sz, address: a};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Hold off until every outstanding request has its result
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] a, input logic [31:0] d);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [31:0] rand_size();
    int p;
    p = $urandom_range(99);
    if (p < 2) return 32'd0;
    if (p < 5) return $urandom;
    if (p < 15) return $urandom_range(1, 20000);
    return $urandom_range(1, 512);
  endfunction

  function automatic logic [31:0] pick_live();
    int k;
    logic [31:0] a;
    if (live_q.size() == 0) return $urandom_range(1, 4096);
    k = $urandom_range(live_q.size() - 1);
    a = live_q[k];
    live_q.delete(k);
    return a;
  endfunction

  // One random request, mostly well-formed
  task automatic random_req();
    int p;
    logic [31:0] a;
    p = $urandom_range(99);
    if (p < 45) send(CMD_ALLOC, rand_size(), $urandom);
    else if (p < 73) send(CMD_FREE, 32'd0, pick_live());
    else if (p < 83) begin
      a = pick_live();
      send(CMD_REALLOC, rand_size(), a);
    end else if (p < 85) send(CMD_REALLOC, rand_size(), 32'd0);
    else if (p < 89) send(CMD_FREE, 32'd0, $urandom);
    else if (p < 92) send(CMD_FREE, 32'd0, 32'd0);
    else if (p < 95) begin
      a = pick_live() + 32'($urandom_range(1, 8));
      send(p[0] ? CMD_REALLOC : CMD_FREE, rand_size(), a);
    end else if (p < 97) send(CMD_REALLOC, $urandom, $urandom);
    else begin
      live_q.delete();
      send(CMD_INIT, $urandom, $urandom);
    end
  endtask

  logic [31:0] init_set [6] = '{32'd65536, 32'd4096, 32'd1, 32'd0, 32'hFFFF_FFFF,
                                32'd20000};
  logic [31:0] limit_set [6] = '{32'd16777216, 32'd8192, 32'd4096, 32'hFFFF_FFFF,
                                 32'hFFFF_FFFF, 32'd0};

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    calm = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: requests before init, then known offsets after init
    send(CMD_ALLOC, 32'd16, 32'd0);
    send(CMD_ALLOC, 32'd0, 32'd0);
    send(CMD_FREE, 32'd0, 32'd64);
    send(CMD_FREE, 32'd0, 32'd0);
    send(CMD_REALLOC, 32'd16, 32'd0);
    send(CMD_INIT, 32'd0, 32'd0);
    send(CMD_FREE, 32'd0, 32'd0);
    send(CMD_FREE, 32'd0, 32'h1234);
    send(CMD_ALLOC, 32'd100, 32'd0);
    send(CMD_FREE, 32'd0, 32'd16);
    send(CMD_FREE, 32'd0, 32'd16);
    send(CMD_ALLOC, 32'd65520, 32'd0);
    send(CMD_ALLOC, 32'd1, 32'd0);
    send(CMD_ALLOC, 32'hFFFF_FFFF, 32'd0);
    send(CMD_REALLOC, 32'd0, 32'd65552);
    send(CMD_REALLOC, 32'd8, 32'd16);
    send(CMD_REALLOC, 32'd5, 32'h0BAD_0000);
    send(CMD_REALLOC, 32'd9000, 32'd16);
    send(CMD_FREE, 32'd0, 32'hFFFF_FFFF);
    send(CMD_ALLOC, 32'hFFFF_FFF0, 32'd0);
    send(CMD_INIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(CMD_FREE, 32'd0, 32'd16);

    // Random phases, one config setting each
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_reg(REG_INIT_SIZE, init_set[ph]);
      write_reg(REG_LIMIT, limit_set[ph]);
      live_q.delete();
      calm = (ph == 2);
      send(CMD_INIT, $urandom, $urandom);
      for (int n = 0; n < 140; n++) begin
        random_req();
        if (n == 70 && ph == 1) drain();
      end
    end

    drain();
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("first_fit_heap_allocator test passed");
    else $display("first_fit_heap_allocator test failed");
    $finish;
  end

endmodule
